/* rtl/shell_sort_engine_core_assert.svh */
// ----------------------------------------------------------------------------
// shell_sort_engine_core_assert.svh
// assertion macros used by the shell sort engine core
// ----------------------------------------------------------------------------
`ifndef SHELL_SORT_ENGINE_CORE_ASSERT_SVH
`define SHELL_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSE_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg
// shared constants for the shell sort engine
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;

endpackage

/* rtl/shell_sort_engine_core.sv */
// loading accepts one request per cycle; a list is sorted once its last request arrives
// a compare reads its pair in S_READ and checks it in S_CMP; S_OUTER steps start positions and gaps
// the store has one write port, so a swap writes its pair in S_CMP and then in S_SWAP2
// each sorted result is read in S_EMIT and loaded in S_EMIT_LD, which waits out any output stall
// reset clears state, count, gap, sort indexes and the output valid; store contents stay undefined
// ----------------------------------------------------------------------------
// shell_sort_engine_core
// collects signed values, shell sorts them in place and emits them ascending
// ----------------------------------------------------------------------------
`include "shell_sort_engine_core_assert.svh"

module shell_sort_engine_core
  import sse_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic                      final_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_OUTER,
    S_READ,
    S_CMP,
    S_SWAP2,
    S_EMIT,
    S_EMIT_LD
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] gap;
  logic [CW-1:0] outer_idx;
  logic [AW-1:0] inner_idx;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [DATA_WIDTH-1:0]        wr_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr_a;
  logic [AW-1:0]                rd_addr_b;
  logic signed [DATA_WIDTH-1:0] rd_data_a;
  logic signed [DATA_WIDTH-1:0] rd_data_b;

  logic          in_acc;
  logic          not_full;
  logic [CW-1:0] count_next;
  logic [CW:0]   ig_sum;
  logic [CW-1:0] jg_sum;
  logic          swap_needed;
  logic          is_final;
  logic          out_free;

  assign in_stall    = (state != S_LOAD);
  assign in_acc      = in_valid && !in_stall;
  assign not_full    = (count < CW'(DEPTH));
  assign count_next  = not_full ? count + CW'(1) : count;
  assign ig_sum      = {1'b0, outer_idx} + {1'b0, gap};
  assign jg_sum      = CW'(inner_idx) + gap;
  assign swap_needed = (rd_data_a > rd_data_b);
  assign is_final    = ((outer_idx + CW'(1)) == count);
  assign out_free    = !out_valid || !out_stall;

  // store port steering
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = count[AW-1:0];
    wr_data   = DATA_WIDTH'(value);
    rd_en     = 1'b0;
    rd_addr_a = inner_idx;
    rd_addr_b = jg_sum[AW-1:0];
    unique case (state)
      S_LOAD: begin
        wr_en = in_acc && not_full;
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_CMP: begin
        wr_en   = swap_needed;
        wr_addr = inner_idx;
        wr_data = rd_data_b;
      end
      S_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = jg_sum[AW-1:0];
        wr_data = rd_data_a;
      end
      S_EMIT: begin
        rd_en     = 1'b1;
        rd_addr_a = outer_idx[AW-1:0];
        rd_addr_b = outer_idx[AW-1:0];
      end
      S_OUTER, S_EMIT_LD: begin
      end
      default: begin
      end
    endcase
  end

  sse_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      gap       <= '0;
      outer_idx <= '0;
      inner_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      // the emit-load state reloads the output register itself when it frees up
      if (out_valid && !out_stall && state != S_EMIT_LD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            count <= count_next;
            if (last) begin
              gap       <= count_next >> 1;
              outer_idx <= '0;
              // a single element needs no sorting
              state     <= ((count_next >> 1) == '0) ? S_EMIT : S_OUTER;
            end
          end
        end
        S_OUTER: begin
          if (ig_sum < {1'b0, count}) begin
            inner_idx <= outer_idx[AW-1:0];
            state     <= S_READ;
          end else begin
            gap       <= gap >> 1;
            outer_idx <= '0;
            if ((gap >> 1) == '0) begin
              state <= S_EMIT;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (swap_needed) begin
            state <= S_SWAP2;
          end else begin
            outer_idx <= outer_idx + CW'(1);
            state     <= S_OUTER;
          end
        end
        S_SWAP2: begin
          if (inner_idx == '0) begin
            outer_idx <= outer_idx + CW'(1);
            state     <= S_OUTER;
          end else begin
            inner_idx <= inner_idx - AW'(1);
            state     <= S_READ;
          end
        end
        S_EMIT: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            sorted_value <= VALUE_W'(rd_data_a);
            final_res    <= is_final;
            if (is_final) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              outer_idx <= outer_idx + CW'(1);
              state     <= S_EMIT;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `SSE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "count above depth")
  `SSE_ASSERT_NOW(a_pair_in_list, clk, rst, state == S_READ,
    gap != '0 && jg_sum < count, "compare pair outside the list")
  `SSE_ASSERT_NOW(a_sort_write_in_list, clk, rst, wr_en && state != S_LOAD,
    CW'(wr_addr) < count, "sort write outside the list")
  `SSE_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(sorted_value) && $stable(final_res), "stalled result changed")

endmodule

/* rtl/sse_store.sv */
// ----------------------------------------------------------------------------
// sse_store
// element store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module sse_store
  import sse_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0]        wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_b,
  output logic signed [DATA_WIDTH-1:0] rd_data_a,
  output logic signed [DATA_WIDTH-1:0] rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
